### hw/rtl/tvh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Traffic value histogram package
// Shared sizes, payload structs, status codes and state types.
// ----------------------------------------------------------------------------
package tvh_pkg;

   localparam int NUM_BINS    = 1024;
   localparam int COUNT_WIDTH = 32;

   localparam int BIN_W   = $clog2(NUM_BINS);
   localparam int CELLS_W = 11;
   localparam int MAX_W   = 31;
   localparam int DIVD_W  = MAX_W + CELLS_W;
   localparam int QUO_W   = CELLS_W;
   localparam int STEP_W  = $clog2(QUO_W);
   localparam int OUT_W   = 32;
   localparam int CSR_W   = 31;

   localparam logic [CELLS_W-1:0] CELLS_RESET = CELLS_W'(1024);
   localparam logic [MAX_W-1:0]   MAX_RESET   = MAX_W'(65535);
   localparam logic [CELLS_W-1:0] CELLS_LIMIT = CELLS_W'(NUM_BINS);

   typedef enum logic [2:0] {
      ST_COUNTED      = 3'd0,
      ST_UNDERFLOW    = 3'd1,
      ST_OVERFLOW     = 3'd2,
      ST_READ_DONE    = 3'd3,
      ST_READ_INVALID = 3'd4
   } status_type;

   typedef enum logic {
      CMD_PUT  = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_CELLS_IN_USE      = 1'b0,
      CSR_MAX_TRAFFIC_VALUE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] traffic_value;
      logic [9:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  bin_number;
      logic [31:0] bin_count;
      logic [31:0] counted_total;
      logic [31:0] overflow_total;
      logic [31:0] underflow_total;
   } rsp_type;

   typedef struct packed {
      status_type       status;
      logic [BIN_W-1:0] bin;
   } job_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_CLEAR,
      B_IDLE,
      B_DONE
   } back_state_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      sat_inc = (c == {COUNT_WIDTH{1'b1}}) ? c : c + COUNT_WIDTH'(1);
   endfunction

endpackage
`default_nettype wire

### hw/rtl/tvh_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Histogram front end
// Accepts transactions, classifies them and finds the bin of an in-range
// sample with a serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tvh_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     clear_done,
   input  wire logic [tvh_pkg::CELLS_W-1:0] cells_eff,
   input  wire logic [tvh_pkg::MAX_W-1:0]   max_eff,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire tvh_pkg::req_type         req_data,
   output logic                          push_valid,
   input  wire logic                     push_ready,
   output tvh_pkg::job_type              push_job
);
   import tvh_pkg::*;

   front_state_type      state_ff, state_in;
   job_type              job_ff, job_in;
   logic [DIVD_W-1:0]    rem_ff, rem_in;
   logic [DIVD_W-1:0]    div_ff, div_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [CELLS_W-1:0]   cells_ff, cells_in;
   logic [DIVD_W-1:0]    product;
   logic [QUO_W-1:0]     quo_next;
   logic                 take;

   assign product = DIVD_W'(req_data.traffic_value[MAX_W-1:0]) * DIVD_W'(cells_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff   <= job_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      cells_ff <= cells_in;
   end

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      quo_in     = quo_ff;
      step_in    = step_ff;
      cells_in   = cells_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      take       = 1'b0;
      quo_next   = {quo_ff[QUO_W-2:0], (rem_ff >= div_ff)};
      unique case (state_ff)
         F_IDLE: begin
            req_ready = clear_done;
            take      = req_valid && clear_done;
            if (take) begin
               state_in = F_PUSH;
               job_in   = '{status: ST_READ_INVALID, bin: '0};
               if (req_data.cmd == CMD_READ) begin
                  if (CELLS_W'(req_data.read_index) < cells_eff) begin
                     job_in = '{status: ST_READ_DONE, bin: BIN_W'(req_data.read_index)};
                  end
               end else if (req_data.traffic_value[31]) begin
                  job_in.status = ST_UNDERFLOW;
               end else if (req_data.traffic_value[MAX_W-1:0] > max_eff) begin
                  job_in.status = ST_OVERFLOW;
               end else begin
                  job_in.status = ST_COUNTED;
                  rem_in        = product;
                  div_in        = DIVD_W'(max_eff) << (QUO_W - 1);
                  quo_in        = '0;
                  step_in       = '0;
                  cells_in      = cells_eff;
                  state_in      = F_DIV;
               end
            end
         end
         F_DIV: begin
            if (rem_ff >= div_ff) begin
               rem_in = rem_ff - div_ff;
            end
            quo_in  = quo_next;
            div_in  = div_ff >> 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               state_in = F_PUSH;
               if (quo_next >= cells_ff) begin
                  job_in.bin = BIN_W'(cells_ff - CELLS_W'(1));
               end else begin
                  job_in.bin = BIN_W'(quo_next);
               end
            end
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign push_job = job_ff;

endmodule
`default_nettype wire

### hw/rtl/tvh_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Histogram job queue
// Two-entry queue of classified jobs between the front and back ends.
// ----------------------------------------------------------------------------
module tvh_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire tvh_pkg::job_type push_job,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output tvh_pkg::job_type      pop_job
);
   import tvh_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/tvh_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Histogram back end
// Holds the bin count memory and the totals, clears the memory after reset,
// carries out each job (a read-modify-write for a counted sample) and drives the result.
// ----------------------------------------------------------------------------
module tvh_back (
   input  wire logic             clock,
   input  wire logic             reset,
   output logic                  clear_done,
   input  wire logic             pop_valid,
   output logic                  pop_ready,
   input  wire tvh_pkg::job_type pop_job,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tvh_pkg::rsp_type      rsp_data
);
   import tvh_pkg::*;

   logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;

   back_state_type         state_ff, state_in;
   logic [BIN_W-1:0]       clr_ff, clr_in;
   job_type                job_ff, job_in;
   logic [COUNT_WIDTH-1:0] counted_ff, counted_in;
   logic [COUNT_WIDTH-1:0] over_ff, over_in;
   logic [COUNT_WIDTH-1:0] under_ff, under_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   wr_en;
   logic [BIN_W-1:0]       wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic                   rd_en;
   logic [COUNT_WIDTH-1:0] new_count;
   logic                   out_free;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[pop_job.bin];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         counted_ff   <= '0;
         over_ff      <= '0;
         under_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         counted_ff   <= counted_in;
         over_ff      <= over_in;
         under_ff     <= under_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign new_count = sat_inc(rd_data_ff);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      job_in       = job_ff;
      counted_in   = counted_ff;
      over_in      = over_ff;
      under_in     = under_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = job_ff.bin;
      wr_data      = new_count;
      rd_en        = 1'b0;
      pop_ready    = 1'b0;
      clear_done   = 1'b1;
      unique case (state_ff)
         B_CLEAR: begin
            clear_done = 1'b0;
            wr_en      = 1'b1;
            wr_addr    = clr_ff;
            wr_data    = '0;
            clr_in     = clr_ff + BIN_W'(1);
            if (clr_ff == BIN_W'(NUM_BINS - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               rd_en    = 1'b1;
               job_in   = pop_job;
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (out_free) begin
               state_in          = B_IDLE;
               rsp_valid_in      = 1'b1;
               rsp_in.status     = job_ff.status;
               rsp_in.bin_number = '0;
               rsp_in.bin_count  = '0;
               unique case (job_ff.status)
                  ST_COUNTED: begin
                     wr_en             = 1'b1;
                     counted_in        = sat_inc(counted_ff);
                     rsp_in.bin_number = 10'(job_ff.bin);
                     rsp_in.bin_count  = OUT_W'(new_count);
                  end
                  ST_UNDERFLOW: begin
                     under_in = sat_inc(under_ff);
                  end
                  ST_OVERFLOW: begin
                     over_in = sat_inc(over_ff);
                  end
                  ST_READ_DONE: begin
                     rsp_in.bin_number = 10'(job_ff.bin);
                     rsp_in.bin_count  = OUT_W'(rd_data_ff);
                  end
                  default: begin
                  end
               endcase
               rsp_in.counted_total   = OUT_W'(counted_in);
               rsp_in.overflow_total  = OUT_W'(over_in);
               rsp_in.underflow_total = OUT_W'(under_in);
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### hw/rtl/traffic_value_histogram.sv
`timescale 1ns / 1ps
`default_nettype none
// A put in range passes the 11-step serial divider, the front end's push
// state, the job queue and the back end's idle and done states before its
// result is registered; other transactions skip the divider. The front end
// takes no new transaction until it has pushed the job of the last one.
// After reset a clearing pass over all 1024 bins zeroes the bin memory, and
// no transaction is accepted until it ends; configuration writes are taken.
// ----------------------------------------------------------------------------
// Traffic value histogram
// Equal-width histogram with saturating bin counts, totals and bin reads.
// ----------------------------------------------------------------------------
module traffic_value_histogram (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic                   csr_index,
   input  wire logic [tvh_pkg::CSR_W-1:0] csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire tvh_pkg::req_type       req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output tvh_pkg::rsp_type            rsp_data
);
   import tvh_pkg::*;

   logic [CELLS_W-1:0] cells_ff, cells_in;
   logic [MAX_W-1:0]   max_ff, max_in;
   logic [CELLS_W-1:0] cells_eff;
   logic [MAX_W-1:0]   max_eff;
   logic               clear_done;
   logic               push_valid, push_ready;
   job_type            push_job;
   logic               pop_valid, pop_ready;
   job_type            pop_job;

   always_comb begin
      cells_in = cells_ff;
      max_in   = max_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CELLS_IN_USE:      cells_in = csr_wdata[CELLS_W-1:0];
            CSR_MAX_TRAFFIC_VALUE: max_in   = csr_wdata[MAX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= CELLS_RESET;
         max_ff   <= MAX_RESET;
      end else begin
         cells_ff <= cells_in;
         max_ff   <= max_in;
      end
   end

   always_comb begin
      if (cells_ff == '0) begin
         cells_eff = CELLS_W'(1);
      end else if (cells_ff > CELLS_LIMIT) begin
         cells_eff = CELLS_LIMIT;
      end else begin
         cells_eff = cells_ff;
      end
      max_eff = (max_ff == '0) ? MAX_W'(1) : max_ff;
   end

   tvh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .clear_done (clear_done),
      .cells_eff  (cells_eff),
      .max_eff    (max_eff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   tvh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   tvh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .clear_done (clear_done),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
